// ===== sv/wbsv_pkg.sv =====
// shared widths, register codes and item types of the blend shape vertex core
`default_nettype none
package wbsv_pkg;

  // field and datapath widths
  localparam int unsigned POS_W   = 32;
  localparam int unsigned CHAN_W  = 17;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned COEF_W  = 33;
  localparam int unsigned C2_W    = 34;
  localparam int unsigned WGT_W   = 26;
  localparam int unsigned M1_W    = 34;
  localparam int unsigned M2_W    = 33;
  localparam int unsigned LO_W    = 17;
  localparam int unsigned PLO_W   = 52;
  localparam int unsigned PHI_W   = 50;
  localparam int unsigned PROD_W  = 67;
  localparam int unsigned DIVS_W  = 25;
  localparam int unsigned DEN_W   = 26;
  localparam int unsigned NUM_W   = 62;
  localparam int unsigned U_W     = 61;
  localparam int unsigned TERM_W  = 51;
  localparam int unsigned EXTRA_W = 55;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned IN_W    = 184;
  localparam int unsigned LANES   = 3;

  // register index codes
  typedef enum logic [2:0] {
    REG_ENVELOPE  = 3'd0,
    REG_WEIGHT_A  = 3'd1,
    REG_WEIGHT_B  = 3'd2,
    REG_WEIGHT_C  = 3'd3,
    REG_SEQ_MODE  = 3'd4,
    REG_TGT_EN    = 3'd5,
    REG_USE_COLOR = 3'd6
  } reg_idx_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic signed [CFG_W-1:0] envelope;
    logic signed [CFG_W-1:0] weight_a;
    logic signed [CFG_W-1:0] weight_b;
    logic signed [CFG_W-1:0] weight_c;
    logic                    seq_mode;
    logic [2:0]              target_en;
    logic                    use_color;
  } cfg_t;

  // item after the front: deltas plus scaled coefficients and weight
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] delta_a;
    logic signed [POS_W-1:0] delta_b;
    logic signed [POS_W-1:0] delta_c;
    logic signed [C2_W-1:0]  c2_a;
    logic signed [C2_W-1:0]  c2_b;
    logic signed [C2_W-1:0]  c2_c;
    logic signed [WGT_W-1:0] w;
  } item_t;

  // sideband carried alongside the divider
  typedef struct packed {
    logic                      use_div;
    logic                      neg;
    logic                      flag;
    logic signed [EXTRA_W-1:0] extra;
  } side_t;

endpackage
`default_nettype wire

// ===== sv/wbsv_front.sv =====
// front: input register and colour scaling of coefficients and weight
`default_nettype none
module wbsv_front (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire  [wbsv_pkg::IN_W-1:0]              in_data_i,
  input  wbsv_pkg::cfg_t                         cfg_i,
  input  wire signed [wbsv_pkg::COEF_W-1:0]      coef_a_i,
  input  wire signed [wbsv_pkg::COEF_W-1:0]      coef_b_i,
  input  wire signed [wbsv_pkg::COEF_W-1:0]      coef_c_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output wbsv_pkg::item_t                        out_item_o
);

  logic                  f0_v_q, f1_v_q, en_f;
  logic [wbsv_pkg::IN_W-1:0] raw_q;
  wbsv_pkg::item_t       item_d, item_q;

  logic signed [50:0] pa, pb, pc;
  logic signed [41:0] pw;
  logic [wbsv_pkg::CHAN_W-1:0] red, green, blue;

  assign en_f       = !f1_v_q || out_ready_i;
  assign in_ready_o = !f0_v_q || en_f;

  assign red   = raw_q[144:128];
  assign green = raw_q[161:145];
  assign blue  = raw_q[178:162];

  // colour scaling, one multiplier per coefficient
  assign pa = coef_a_i * $signed({1'b0, red});
  assign pb = coef_b_i * $signed({1'b0, green});
  assign pc = coef_c_i * $signed({1'b0, blue});
  assign pw = cfg_i.envelope * $signed({1'b0, red});

  always_comb begin
    item_d.pos     = $signed(raw_q[31:0]);
    item_d.delta_a = $signed(raw_q[63:32]);
    item_d.delta_b = $signed(raw_q[95:64]);
    item_d.delta_c = $signed(raw_q[127:96]);
    if (cfg_i.use_color) begin
      item_d.c2_a = wbsv_pkg::C2_W'((pa + 51'sd32768) >>> 16);
      item_d.c2_b = wbsv_pkg::C2_W'((pb + 51'sd32768) >>> 16);
      item_d.c2_c = wbsv_pkg::C2_W'((pc + 51'sd32768) >>> 16);
      item_d.w    = wbsv_pkg::WGT_W'((pw + 42'sd32768) >>> 16);
    end else begin
      item_d.c2_a = wbsv_pkg::C2_W'(coef_a_i);
      item_d.c2_b = wbsv_pkg::C2_W'(coef_b_i);
      item_d.c2_c = wbsv_pkg::C2_W'(coef_c_i);
      item_d.w    = wbsv_pkg::WGT_W'(cfg_i.envelope);
    end
  end

  // two-stage front pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
      f1_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        f0_v_q <= in_valid_i;
        raw_q  <= in_data_i;
      end
      if (en_f) begin
        f1_v_q <= f0_v_q;
        item_q <= item_d;
      end
    end
  end

  assign out_valid_o = f1_v_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

// ===== sv/wbsv_queue.sv =====
// two-entry queue between front and back
`default_nettype none
module wbsv_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_valid_i,
  output logic            push_ready_o,
  input  wbsv_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  wire             pop_ready_i,
  output wbsv_pkg::item_t pop_item_o
);

  wbsv_pkg::item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = mem_q[rd_ptr_q];

  // pointers, count and storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        mem_q[wr_ptr_q] <= push_item_i;
        wr_ptr_q        <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/wbsv_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module wbsv_div (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           en_i,
  input  wire                           valid_i,
  input  wire  [wbsv_pkg::U_W-1:0]      u_i,
  input  wire  [wbsv_pkg::DEN_W-1:0]    den_i,
  input  wbsv_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [wbsv_pkg::U_W-1:0]      q_o,
  output wbsv_pkg::side_t               side_o
);

  localparam int unsigned N = wbsv_pkg::U_W;

  logic                          v_q   [N];
  logic [wbsv_pkg::U_W-1:0]      u_q   [N];
  logic [wbsv_pkg::U_W-1:0]      q_q   [N];
  logic [wbsv_pkg::DEN_W-1:0]    rem_q [N];
  logic [wbsv_pkg::DEN_W-1:0]    den_q [N];
  wbsv_pkg::side_t               sd_q  [N];

  logic [wbsv_pkg::U_W-1:0]      u_d   [N];
  logic [wbsv_pkg::U_W-1:0]      q_d   [N];
  logic [wbsv_pkg::DEN_W-1:0]    rem_d [N];

  // one shift-compare-subtract per stage
  always_comb begin
    logic [wbsv_pkg::U_W-1:0]   pu, pq;
    logic [wbsv_pkg::DEN_W-1:0] pr, pd;
    logic [wbsv_pkg::DEN_W:0]   trial;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        pu = u_i;
        pq = '0;
        pr = '0;
        pd = den_i;
      end else begin
        pu = u_q[s-1];
        pq = q_q[s-1];
        pr = rem_q[s-1];
        pd = den_q[s-1];
      end
      trial  = {pr, pu[wbsv_pkg::U_W-1]};
      u_d[s] = {pu[wbsv_pkg::U_W-2:0], 1'b0};
      if (trial >= {1'b0, pd}) begin
        rem_d[s] = wbsv_pkg::DEN_W'(trial - {1'b0, pd});
        q_d[s]   = {pq[wbsv_pkg::U_W-2:0], 1'b1};
      end else begin
        rem_d[s] = wbsv_pkg::DEN_W'(trial);
        q_d[s]   = {pq[wbsv_pkg::U_W-2:0], 1'b0};
      end
    end
  end

  // stage registers, all advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < N; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      for (int s = 0; s < N; s++) begin
        v_q[s]   <= (s == 0) ? valid_i : v_q[(s == 0) ? 0 : s-1];
        u_q[s]   <= u_d[s];
        q_q[s]   <= q_d[s];
        rem_q[s] <= rem_d[s];
        den_q[s] <= (s == 0) ? den_i : den_q[(s == 0) ? 0 : s-1];
        sd_q[s]  <= (s == 0) ? side_i : sd_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign q_o     = q_q[N-1];
  assign side_o  = sd_q[N-1];

endmodule
`default_nettype wire

// ===== sv/wbsv_back.sv =====
// back: branch selection, split multiply, rounding, division and saturation
`default_nettype none
module wbsv_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wbsv_pkg::item_t                  in_item_i,
  input  wbsv_pkg::cfg_t                   cfg_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [wbsv_pkg::POS_W-1:0]       out_pos_o,
  output logic                             out_flag_o
);

  localparam int unsigned L = wbsv_pkg::LANES;

  logic en;
  logic b1_v_q, b2_v_q, b3_v_q, b4_v_q, out_v_q;

  // stage 1 outputs
  logic signed [wbsv_pkg::M1_W-1:0]  m1_d [L], m1_q [L];
  logic signed [wbsv_pkg::M2_W-1:0]  m2_d [L], m2_q [L];
  logic [wbsv_pkg::DIVS_W-1:0]       dv_d, dv_q [3];
  logic signed [wbsv_pkg::M2_W-1:0]  base_d, base_q [3];
  logic                              udiv_d, flag_d;
  logic                              udiv_q [3], flag_q [3];
  logic signed [wbsv_pkg::POS_W-1:0] pos_q [3];

  // stage 2 and 3
  logic signed [wbsv_pkg::PLO_W-1:0]  plo_q [L];
  logic signed [wbsv_pkg::PHI_W-1:0]  phi_q [L];
  logic signed [wbsv_pkg::PROD_W-1:0] prod_q [L];

  // stage 4 to divider
  logic signed [wbsv_pkg::NUM_W-1:0]  num;
  logic [wbsv_pkg::U_W-1:0]           u_d, u_q;
  logic [wbsv_pkg::DEN_W-1:0]         den_q;
  wbsv_pkg::side_t                    side_d, side_q;
  logic signed [wbsv_pkg::TERM_W-1:0] term [L];

  logic                         dv_valid;
  logic [wbsv_pkg::U_W-1:0]     q_u;
  wbsv_pkg::side_t              dv_side;
  logic signed [wbsv_pkg::NUM_W-1:0] q_s;
  logic signed [wbsv_pkg::ACC_W-1:0] acc;
  logic [wbsv_pkg::POS_W-1:0]   pos_d, pos_out_q;
  logic                         flag_out_q;

  logic signed [wbsv_pkg::WGT_W-1:0]  w;
  logic signed [wbsv_pkg::POS_W-1:0]  da, db, dc;
  logic                               on_a, on_b, on_c, ordered;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  assign w    = in_item_i.w;
  assign da   = in_item_i.delta_a;
  assign db   = in_item_i.delta_b;
  assign dc   = in_item_i.delta_c;
  assign on_a = cfg_i.target_en[0];
  assign on_b = cfg_i.target_en[1];
  assign on_c = cfg_i.target_en[2];
  assign ordered = (cfg_i.weight_a >= 0) && (cfg_i.weight_a <= cfg_i.weight_b)
                && (cfg_i.weight_b <= cfg_i.weight_c);

  // classify: pick multiplier operands, divisor and base delta
  always_comb begin
    for (int k = 0; k < L; k++) begin
      m1_d[k] = '0;
      m2_d[k] = '0;
    end
    dv_d   = wbsv_pkg::DIVS_W'(1);
    base_d = '0;
    udiv_d = 1'b0;
    flag_d = 1'b0;
    if (!cfg_i.seq_mode) begin
      if (on_a) begin
        m1_d[0] = in_item_i.c2_a;
        m2_d[0] = wbsv_pkg::M2_W'(da);
      end
      if (on_b) begin
        m1_d[1] = in_item_i.c2_b;
        m2_d[1] = wbsv_pkg::M2_W'(db);
      end
      if (on_c) begin
        m1_d[2] = in_item_i.c2_c;
        m2_d[2] = wbsv_pkg::M2_W'(dc);
      end
    end else if (!ordered) begin
      flag_d = 1'b1;
    end else begin
      udiv_d = 1'b1;
      if (on_a && w <= cfg_i.weight_a) begin
        if (cfg_i.weight_a > 0) begin
          m1_d[0] = wbsv_pkg::M1_W'(w);
          m2_d[0] = wbsv_pkg::M2_W'(da);
          dv_d    = wbsv_pkg::DIVS_W'(cfg_i.weight_a);
        end
      end else if (on_a && on_b && cfg_i.weight_a < w && w <= cfg_i.weight_b) begin
        m1_d[0] = wbsv_pkg::M1_W'(w) - wbsv_pkg::M1_W'(cfg_i.weight_a);
        m2_d[0] = wbsv_pkg::M2_W'(db) - wbsv_pkg::M2_W'(da);
        dv_d    = wbsv_pkg::DIVS_W'(cfg_i.weight_b) - wbsv_pkg::DIVS_W'(cfg_i.weight_a);
        base_d  = wbsv_pkg::M2_W'(da);
      end else if (!on_b && cfg_i.weight_a <= w) begin
        base_d = wbsv_pkg::M2_W'(da);
      end else if (on_b && on_c && cfg_i.weight_b < w) begin
        if (cfg_i.weight_c == cfg_i.weight_b) begin
          base_d = wbsv_pkg::M2_W'(dc);
        end else begin
          m1_d[0] = wbsv_pkg::M1_W'(w) - wbsv_pkg::M1_W'(cfg_i.weight_b);
          m2_d[0] = wbsv_pkg::M2_W'(dc) - wbsv_pkg::M2_W'(db);
          dv_d    = wbsv_pkg::DIVS_W'(cfg_i.weight_c) - wbsv_pkg::DIVS_W'(cfg_i.weight_b);
          base_d  = wbsv_pkg::M2_W'(db);
        end
      end else if (!on_c && cfg_i.weight_b <= w) begin
        base_d = wbsv_pkg::M2_W'(db);
      end
    end
  end

  // parallel lanes round by two to the sixteenth, sequential lane feeds the divider
  always_comb begin
    for (int k = 0; k < L; k++) begin
      term[k] = wbsv_pkg::TERM_W'((prod_q[k] + 67'sd32768) >>> 16);
    end
    num = {prod_q[0][wbsv_pkg::NUM_W-2:0], 1'b0}
        + $signed({{(wbsv_pkg::NUM_W-wbsv_pkg::DIVS_W){1'b0}}, dv_q[2]});
    u_d = num[wbsv_pkg::NUM_W-1] ? ~num[wbsv_pkg::U_W-1:0] : num[wbsv_pkg::U_W-1:0];
    side_d.use_div = udiv_q[2];
    side_d.neg     = num[wbsv_pkg::NUM_W-1];
    side_d.flag    = flag_q[2];
    if (udiv_q[2]) begin
      side_d.extra = wbsv_pkg::EXTRA_W'(pos_q[2]) + wbsv_pkg::EXTRA_W'(base_q[2]);
    end else begin
      side_d.extra = wbsv_pkg::EXTRA_W'(pos_q[2]) + wbsv_pkg::EXTRA_W'(term[0])
                   + wbsv_pkg::EXTRA_W'(term[1]) + wbsv_pkg::EXTRA_W'(term[2]);
    end
  end

  // front-end pipeline stages of the back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      b4_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q <= in_valid_i;
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
      b4_v_q <= b3_v_q;
      for (int k = 0; k < L; k++) begin
        m1_q[k]   <= m1_d[k];
        m2_q[k]   <= m2_d[k];
        plo_q[k]  <= m1_q[k] * $signed({1'b0, m2_q[k][wbsv_pkg::LO_W-1:0]});
        phi_q[k]  <= m1_q[k] * $signed(m2_q[k][wbsv_pkg::M2_W-1:wbsv_pkg::LO_W]);
        prod_q[k] <= (wbsv_pkg::PROD_W'(phi_q[k]) <<< wbsv_pkg::LO_W)
                   + wbsv_pkg::PROD_W'(plo_q[k]);
      end
      dv_q[0]   <= dv_d;
      base_q[0] <= base_d;
      udiv_q[0] <= udiv_d;
      flag_q[0] <= flag_d;
      pos_q[0]  <= in_item_i.pos;
      for (int s = 1; s < 3; s++) begin
        dv_q[s]   <= dv_q[s-1];
        base_q[s] <= base_q[s-1];
        udiv_q[s] <= udiv_q[s-1];
        flag_q[s] <= flag_q[s-1];
        pos_q[s]  <= pos_q[s-1];
      end
      u_q    <= u_d;
      den_q  <= {dv_q[2], 1'b0};
      side_q <= side_d;
    end
  end

  wbsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b4_v_q),
    .u_i     (u_q),
    .den_i   (den_q),
    .side_i  (side_q),
    .valid_o (dv_valid),
    .q_o     (q_u),
    .side_o  (dv_side)
  );

  // sign restore of the floor quotient, final sum and saturation
  always_comb begin
    q_s = dv_side.neg ? ~$signed({1'b0, q_u}) : $signed({1'b0, q_u});
    acc = wbsv_pkg::ACC_W'(dv_side.extra);
    if (dv_side.use_div) begin
      acc = acc + wbsv_pkg::ACC_W'(q_s);
    end
    if (acc > 64'sd2147483647) begin
      pos_d = 32'h7fff_ffff;
    end else if (acc < -64'sd2147483648) begin
      pos_d = 32'h8000_0000;
    end else begin
      pos_d = acc[wbsv_pkg::POS_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q    <= dv_valid;
      pos_out_q  <= pos_d;
      flag_out_q <= dv_side.flag;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_pos_o   = pos_out_q;
  assign out_flag_o  = flag_out_q;

endmodule
`default_nettype wire

// ===== sv/weighted_blend_shape_vertex_core.sv =====
// top level: configuration registers, front, queue and back
`default_nettype none
// Blend shape deformer for one vertex coordinate in Q16.16. One item per
// cycle is accepted and one result per cycle is delivered when the output
// side is not stalled. From input accept to result valid an item passes
// two front stages, the two-entry queue, four back stages, then the
// 61-stage pipelined divider (one quotient bit per stage) that serves the
// in-between interpolation, and the output register. Parallel-mode items
// travel the same pipeline so results keep input order. Configuration is
// taken over the APB port and must only change while the block holds no
// item; the weight products are registered from the written configuration
// in the cycle after the write.
module weighted_blend_shape_vertex_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // position[31:0], delta_a[63:32], delta_b[95:64], delta_c[127:96],
  // color_red[144:128], color_green[161:145], color_blue[178:162], zero pad
  input  wire  [183:0]               s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  // new_position[31:0]
  output logic [31:0]                m_axis_tdata,
  // weights_unordered[0]
  output logic [0:0]                 m_axis_tuser,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [4:0]                 paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  wbsv_pkg::cfg_t   cfg_q;
  wbsv_pkg::reg_idx_e idx;
  logic             wr;
  logic signed [47:0] ea, eb, ec;
  logic signed [wbsv_pkg::COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;

  logic            f_valid, f_ready, q_valid, q_ready;
  wbsv_pkg::item_t f_item, q_item;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = wbsv_pkg::reg_idx_e'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.envelope  <= 24'sd65536;
      cfg_q.weight_a  <= 24'sd65536;
      cfg_q.weight_b  <= 24'sd65536;
      cfg_q.weight_c  <= 24'sd65536;
      cfg_q.seq_mode  <= 1'b0;
      cfg_q.target_en <= 3'd0;
      cfg_q.use_color <= 1'b0;
    end else if (wr) begin
      case (idx)
        wbsv_pkg::REG_ENVELOPE:  cfg_q.envelope  <= $signed(pwdata[23:0]);
        wbsv_pkg::REG_WEIGHT_A:  cfg_q.weight_a  <= $signed(pwdata[23:0]);
        wbsv_pkg::REG_WEIGHT_B:  cfg_q.weight_b  <= $signed(pwdata[23:0]);
        wbsv_pkg::REG_WEIGHT_C:  cfg_q.weight_c  <= $signed(pwdata[23:0]);
        wbsv_pkg::REG_SEQ_MODE:  cfg_q.seq_mode  <= pwdata[0];
        wbsv_pkg::REG_TGT_EN:    cfg_q.target_en <= pwdata[2:0];
        wbsv_pkg::REG_USE_COLOR: cfg_q.use_color <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      wbsv_pkg::REG_ENVELOPE:  prdata = {8'd0, cfg_q.envelope};
      wbsv_pkg::REG_WEIGHT_A:  prdata = {8'd0, cfg_q.weight_a};
      wbsv_pkg::REG_WEIGHT_B:  prdata = {8'd0, cfg_q.weight_b};
      wbsv_pkg::REG_WEIGHT_C:  prdata = {8'd0, cfg_q.weight_c};
      wbsv_pkg::REG_SEQ_MODE:  prdata = {31'd0, cfg_q.seq_mode};
      wbsv_pkg::REG_TGT_EN:    prdata = {29'd0, cfg_q.target_en};
      wbsv_pkg::REG_USE_COLOR: prdata = {31'd0, cfg_q.use_color};
      default:                 prdata = 32'd0;
    endcase
  end

  // envelope times weight, rounded to Q16.16
  assign ea = cfg_q.envelope * cfg_q.weight_a;
  assign eb = cfg_q.envelope * cfg_q.weight_b;
  assign ec = cfg_q.envelope * cfg_q.weight_c;

  always_ff @(posedge clk_i) begin
    coef_a_q <= wbsv_pkg::COEF_W'((ea + 48'sd32768) >>> 16);
    coef_b_q <= wbsv_pkg::COEF_W'((eb + 48'sd32768) >>> 16);
    coef_c_q <= wbsv_pkg::COEF_W'((ec + 48'sd32768) >>> 16);
  end

  wbsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .cfg_i       (cfg_q),
    .coef_a_i    (coef_a_q),
    .coef_b_i    (coef_b_q),
    .coef_c_i    (coef_c_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_item_o  (f_item)
  );

  wbsv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  wbsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_item_i   (q_item),
    .cfg_i       (cfg_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pos_o   (m_axis_tdata),
    .out_flag_o  (m_axis_tuser[0])
  );

endmodule
`default_nettype wire

// ===== sv/wbsv_checker.sv =====
// port-level checker for the blend shape vertex core and its bind
`default_nettype none
module wbsv_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [0:0]  m_axis_tuser,
  input wire        pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // no result is valid right after reset release
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind weighted_blend_shape_vertex_core wbsv_checker u_wbsv_checker (.*);
`default_nettype wire
